// File: hdl/ssfmt_pkg.sv
// Shared types, constants and segment tables for the seven segment frame formatter.
// No dependencies; every other file of the block imports this package.
package ssfmt_pkg;

   localparam int SLOTS = 7;
   localparam int CNT_W = $clog2(SLOTS);
   localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(SLOTS - 1);

   localparam logic [2:0] FUNC_STRENGTH  = 3'd0;
   localparam logic [2:0] FUNC_CUR_TIME  = 3'd1;
   localparam logic [2:0] FUNC_BEST_TIME = 3'd2;
   localparam logic [2:0] FUNC_BLANK_RED = 3'd3;
   localparam logic [2:0] FUNC_BLANK_ALL = 3'd4;

   localparam logic [6:0]  PCT_MAX      = 7'd100;
   localparam logic [13:0] BEST_MAX     = 14'd9999;
   localparam logic [9:0]  TENTHS_MAX   = 10'd999;
   localparam logic [32:0] ROUND_US     = 33'd50000;
   localparam logic [31:0] CUR_LIMIT_US = 32'd99950000;

   // (us + 50000) / 100000 = ((us + 50000) >> 5) / 3125, the latter by reciprocal
   localparam int          TENTH_SHIFT = 5;
   localparam int          SCALED_W    = 22;
   localparam logic [22:0] RECIP_3125  = 23'd5497559;
   localparam int          RECIP_SHIFT = 34;
   localparam int          SCALE_PROD_W = SCALED_W + 23;

   localparam logic [12:0] HUND_RECIP = 13'd5243;
   localparam int          HUND_SHIFT = 19;
   localparam logic [7:0]  TEN_RECIP  = 8'd205;
   localparam int          TEN_SHIFT  = 11;

   localparam logic [7:0] RED_DP   = 8'h08;
   localparam logic [7:0] GREEN_DP = 8'h20;

   typedef struct packed {
      logic [2:0]  func;
      logic [9:0]  tenths;
      logic [6:0]  pct;
      logic [13:0] best;
   } scaled_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [13:0] num;
      logic [6:0]  hi;
   } split_type;

   typedef struct packed {
      logic [3:0] tens;
      logic [3:0] ones;
   } digit_pair_type;

   function automatic digit_pair_type split10(input logic [6:0] v);
      logic [14:0]    prod;
      digit_pair_type r;
      prod   = 15'(v) * 15'(TEN_RECIP);
      r.tens = prod[TEN_SHIFT +: 4];
      r.ones = 4'(v - 7'(r.tens) * 7'd10);
      return r;
   endfunction

   function automatic logic [7:0] red_seg(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h77;
         4'd1: s = 8'h14;
         4'd2: s = 8'hB3;
         4'd3: s = 8'hB6;
         4'd4: s = 8'hD4;
         4'd5: s = 8'hE6;
         4'd6: s = 8'hE7;
         4'd7: s = 8'h34;
         4'd8: s = 8'hF7;
         4'd9: s = 8'hF6;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] green_seg(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0: s = 8'h5F;
         4'd1: s = 8'h0C;
         4'd2: s = 8'h9B;
         4'd3: s = 8'h9E;
         4'd4: s = 8'hCC;
         4'd5: s = 8'hD6;
         4'd6: s = 8'hD7;
         4'd7: s = 8'h1C;
         4'd8: s = 8'hDF;
         4'd9: s = 8'hDE;
         default: s = 8'h00;
      endcase
      return s;
   endfunction

endpackage

// File: hdl/ssfmt_scale.sv
// Input register and scaling stage: clamps percent and hundredths, rounds microseconds
// to tenths by reciprocal multiply. Depends on ssfmt_pkg.
module ssfmt_scale (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [2:0]             req_func,
   input  logic [31:0]            req_value,
   output logic                   out_vld,
   input  logic                   out_ready,
   output ssfmt_pkg::scaled_type  out_data
);
   import ssfmt_pkg::*;

   logic                        a_vld_ff;
   logic [2:0]                  a_func_ff;
   logic [31:0]                 a_value_ff;
   logic                        b_vld_ff;
   scaled_type                  b_ff;
   scaled_type                  b_in;
   logic                        a_ready;
   logic                        b_ready;
   logic [32:0]                 rounded;
   logic [SCALED_W-1:0]         scaled;
   logic [SCALE_PROD_W-1:0]     prod;

   assign b_ready   = !b_vld_ff || out_ready;
   assign a_ready   = !a_vld_ff || b_ready;
   assign req_stall = !a_ready;

   assign rounded = {1'b0, a_value_ff} + ROUND_US;
   assign scaled  = rounded[TENTH_SHIFT +: SCALED_W];
   assign prod    = SCALE_PROD_W'(scaled) * SCALE_PROD_W'(RECIP_3125);

   always_comb begin
      b_in.func   = a_func_ff;
      b_in.tenths = (a_value_ff >= CUR_LIMIT_US) ? TENTHS_MAX : prod[RECIP_SHIFT +: 10];
      b_in.pct    = (a_value_ff > 32'(PCT_MAX)) ? PCT_MAX : a_value_ff[6:0];
      b_in.best   = (a_value_ff > 32'(BEST_MAX)) ? BEST_MAX : a_value_ff[13:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         if (a_ready) a_vld_ff <= req_valid;
         if (b_ready) b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_valid) begin
         a_func_ff  <= req_func;
         a_value_ff <= req_value;
      end
      if (b_ready && a_vld_ff) b_ff <= b_in;
   end

   assign out_vld  = b_vld_ff;
   assign out_data = b_ff;

endmodule

// File: hdl/ssfmt_split.sv
// Hundreds split stage: picks the number to show and divides it by 100 by reciprocal.
// Depends on ssfmt_pkg.
module ssfmt_split (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_vld,
   output logic                   in_ready,
   input  ssfmt_pkg::scaled_type  in_data,
   output logic                   out_vld,
   input  logic                   out_ready,
   output ssfmt_pkg::split_type   out_data
);
   import ssfmt_pkg::*;

   logic        c_vld_ff;
   split_type   c_ff;
   split_type   c_in;
   logic [26:0] hi_prod;

   assign in_ready = !c_vld_ff || out_ready;

   always_comb begin
      c_in.func = in_data.func;
      case (in_data.func)
         FUNC_STRENGTH: c_in.num = 14'(in_data.pct);
         FUNC_CUR_TIME: c_in.num = 14'(in_data.tenths);
         default:       c_in.num = in_data.best;
      endcase
      hi_prod  = 27'(c_in.num) * 27'(HUND_RECIP);
      c_in.hi  = hi_prod[HUND_SHIFT +: 7];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (in_ready) begin
         c_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_vld) c_ff <= c_in;
   end

   assign out_vld  = c_vld_ff;
   assign out_data = c_ff;

endmodule

// File: hdl/ssfmt_frame.sv
// Digit encode and frame serializer: builds the seven segment bytes of one frame and
// sends them from slot 6 down to slot 0. Depends on ssfmt_pkg.
module ssfmt_frame (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   output logic                  in_ready,
   input  ssfmt_pkg::split_type  in_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_segment_byte,
   output logic                  rsp_last
);
   import ssfmt_pkg::*;

   logic                 frm_vld_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [7:0]           frame_ff [SLOTS];
   logic [7:0]           frame_in [SLOTS];
   logic [6:0]           lo;
   digit_pair_type       hp;
   digit_pair_type       lp;
   logic                 out_take;
   logic                 load;

   assign lo = 7'(in_data.num - 14'(in_data.hi) * 14'd100);
   assign hp = split10(in_data.hi);
   assign lp = split10(lo);

   always_comb begin
      for (int i = 0; i < SLOTS; i++) frame_in[i] = 8'h00;
      case (in_data.func)
         FUNC_STRENGTH: begin
            frame_in[0] = (in_data.hi != 7'd0) ? red_seg(hp.ones) : 8'h00;
            frame_in[1] = (in_data.hi != 7'd0 || lp.tens != 4'd0) ? red_seg(lp.tens) : 8'h00;
            frame_in[2] = red_seg(lp.ones);
         end
         FUNC_CUR_TIME: begin
            frame_in[0] = (in_data.hi != 7'd0) ? red_seg(hp.ones) : 8'h00;
            frame_in[1] = red_seg(lp.tens) | RED_DP;
            frame_in[2] = red_seg(lp.ones);
         end
         FUNC_BEST_TIME: begin
            frame_in[3] = (hp.tens != 4'd0) ? green_seg(hp.tens) : 8'h00;
            frame_in[4] = green_seg(hp.ones) | GREEN_DP;
            frame_in[5] = green_seg(lp.tens);
            frame_in[6] = green_seg(lp.ones);
         end
         FUNC_BLANK_RED, FUNC_BLANK_ALL: begin
         end
         default: begin
         end
      endcase
   end

   assign out_take = frm_vld_ff && !rsp_stall;
   assign in_ready = !frm_vld_ff || (out_take && cnt_ff == LAST_SLOT);
   assign load     = in_ready && in_vld;

   always_ff @(posedge clock) begin
      if (reset) begin
         frm_vld_ff <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         if (in_ready) frm_vld_ff <= in_vld;
         if (out_take) begin
            if (cnt_ff == LAST_SLOT) cnt_ff <= '0;
            else                     cnt_ff <= cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < SLOTS; i++) frame_ff[i] <= frame_in[i];
      end
   end

   assign rsp_valid        = frm_vld_ff;
   assign rsp_segment_byte = frame_ff[LAST_SLOT - cnt_ff];
   assign rsp_last         = (cnt_ff == LAST_SLOT);

   a_last_wraps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> (cnt_ff == '0))
      else $error("slot counter did not wrap after the last byte");

   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last) |=>
         (rsp_valid && cnt_ff == $past(cnt_ff) + CNT_W'(1)))
      else $error("frame dropped or counter skipped mid-frame");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> frm_vld_ff)
      else $error("slot counter moved without a frame");

   a_frame_held: assert property (@(posedge clock) disable iff (reset)
      (frm_vld_ff && !(rsp_valid && !rsp_stall && rsp_last)) |=>
         (frame_ff[0] == $past(frame_ff[0]) && frame_ff[6] == $past(frame_ff[6])))
      else $error("frame overwritten while bytes remain");

endmodule

// File: hdl/seven_segment_frame_formatter.sv
// Seven segment frame formatter: each req_ transaction (func, value) yields seven
// rsp_ transactions of segment bytes, slot 6 first, with rsp_last on slot 0. The byte
// serializer sends one frame at a time; a new item is taken while the previous frame is
// still being sent. From acceptance to the first byte an item passes the input
// register, scaling multiply, hundreds split and frame register. Depends on ssfmt_pkg.
module seven_segment_frame_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_segment_byte,
   output logic        rsp_last
);
   import ssfmt_pkg::*;

   logic       scl_vld;
   logic       scl_ready;
   scaled_type scl_data;
   logic       spl_vld;
   logic       spl_ready;
   split_type  spl_data;

   ssfmt_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_func),
      .req_value (req_value),
      .out_vld   (scl_vld),
      .out_ready (scl_ready),
      .out_data  (scl_data)
   );

   ssfmt_split u_split (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (scl_vld),
      .in_ready  (scl_ready),
      .in_data   (scl_data),
      .out_vld   (spl_vld),
      .out_ready (spl_ready),
      .out_data  (spl_data)
   );

   ssfmt_frame u_frame (
      .clock            (clock),
      .reset            (reset),
      .in_vld           (spl_vld),
      .in_ready         (spl_ready),
      .in_data          (spl_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_segment_byte (rsp_segment_byte),
      .rsp_last         (rsp_last)
   );

endmodule

// File: sim/seven_segment_frame_formatter_tb.sv
// Testbench for seven_segment_frame_formatter: directed and random display requests,
// each checked against seven predicted segment bytes. Uses ssfmt_pkg for func codes.
module seven_segment_frame_formatter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssfmt_pkg::*;

   localparam int          DIGITS          = 7;
   localparam int          DRAIN_CYCLES    = 24;
   localparam int unsigned PERCENT_CAP     = 100;
   localparam int unsigned HUNDREDTHS_CAP  = 9999;
   localparam int unsigned TENTHS_CAP      = 999;
   localparam longint unsigned HALF_TENTH_US = 50000;
   localparam longint unsigned TENTH_US      = 100000;
   localparam logic [7:0]  RED_POINT       = 8'h08;
   localparam logic [7:0]  GREEN_POINT     = 8'h20;
   localparam logic [2:0]  FUNC_SPARE_LO   = FUNC_BLANK_ALL + 3'd1;
   localparam logic [2:0]  FUNC_SPARE_HI   = 3'd7;
   localparam logic [79:0] RED_GLYPHS =
      {8'hF6, 8'hF7, 8'h34, 8'hE7, 8'hE6, 8'hD4, 8'hB6, 8'hB3, 8'h14, 8'h77};
   localparam logic [79:0] GREEN_GLYPHS =
      {8'hDE, 8'hDF, 8'h1C, 8'hD7, 8'hD6, 8'hCC, 8'h9E, 8'h9B, 8'h0C, 8'h5F};

   typedef struct packed {
      logic [2:0]  func;
      logic [31:0] value;
   } display_req_type;

   typedef struct packed {
      logic [7:0] segment_byte;
      logic       last;
   } segment_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = '0;
   logic [31:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_segment_byte;
   logic        rsp_last;

   display_req_type  pending_reqs[$];
   segment_beat_type frame_bytes_due[$];
   int            requests_queued = 0;
   int            requests_issued = 0;
   int            requests_taken = 0;
   int            bytes_taken = 0;
   int            bytes_seen = 0;
   int            req_wait = 0;
   int            req_calm = 0;
   int            rsp_wait = 0;
   int            rsp_calm = 0;
   bit            failed = 1'b0;

   seven_segment_frame_formatter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_segment_byte (rsp_segment_byte),
      .rsp_last         (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] red_glyph(input int unsigned d);
      return RED_GLYPHS[d*8 +: 8];
   endfunction

   function automatic logic [7:0] green_glyph(input int unsigned d);
      return GREEN_GLYPHS[d*8 +: 8];
   endfunction

   // occasional runs of thirteen transactions with no waiting
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = 12;
         return 0;
      end
      return $urandom_range(0, 3);
   endfunction

   function automatic void predict_frame(input logic [2:0] func, input logic [31:0] value);
      logic [7:0]       slot [DIGITS];
      longint unsigned  tenths;
      int unsigned      num;
      int unsigned      secs;
      segment_beat_type beat;
      foreach (slot[i]) slot[i] = 8'h00;
      case (func)
         FUNC_STRENGTH: begin
            num = (value > PERCENT_CAP) ? PERCENT_CAP : value;
            if (num >= 100) slot[0] = red_glyph(num / 100);
            if (num >= 10) slot[1] = red_glyph((num / 10) % 10);
            slot[2] = red_glyph(num % 10);
         end
         FUNC_CUR_TIME: begin
            tenths = (longint'(value) + HALF_TENTH_US) / TENTH_US;
            if (tenths > TENTHS_CAP) tenths = TENTHS_CAP;
            secs = int'(tenths / 10);
            if (secs >= 10) slot[0] = red_glyph(secs / 10);
            slot[1] = red_glyph(secs % 10) | RED_POINT;
            slot[2] = red_glyph(int'(tenths % 10));
         end
         FUNC_BEST_TIME: begin
            num = (value > HUNDREDTHS_CAP) ? HUNDREDTHS_CAP : value;
            secs = num / 100;
            if (secs >= 10) slot[3] = green_glyph(secs / 10);
            slot[4] = green_glyph(secs % 10) | GREEN_POINT;
            slot[5] = green_glyph((num % 100) / 10);
            slot[6] = green_glyph(num % 10);
         end
         default: ;
      endcase
      for (int k = 0; k < DIGITS; k++) begin
         beat.segment_byte = slot[DIGITS - 1 - k];
         beat.last = (k == DIGITS - 1);
         frame_bytes_due.push_back(beat);
      end
   endfunction

   task automatic queue_req(input logic [2:0] func, input logic [31:0] value);
      display_req_type r;
      r.func = func;
      r.value = value;
      pending_reqs.push_back(r);
      requests_queued++;
   endtask

   always @(negedge clock) begin : req_driver
      display_req_type r;
      logic            next_valid;
      if (!reset && !(req_valid && requests_taken != requests_issued)) begin
         next_valid = 1'b0;
         if (req_wait > 0) begin
            req_wait--;
         end else if (pending_reqs.size() != 0) begin
            r = pending_reqs.pop_front();
            req_func <= r.func;
            req_value <= r.value;
            requests_issued++;
            req_wait = draw_wait(req_calm);
            next_valid = 1'b1;
         end
         req_valid <= next_valid;
      end
   end

   always @(negedge clock) begin : rsp_backpressure
      if (!reset) begin
         if (bytes_seen != bytes_taken) begin
            bytes_seen = bytes_taken;
            rsp_wait = draw_wait(rsp_calm);
         end
         rsp_stall <= (rsp_wait > 0);
         if (rsp_wait > 0) rsp_wait--;
      end
   end

   always @(posedge clock) begin : frame_monitor
      segment_beat_type due;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_frame(req_func, req_value);
            requests_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            bytes_taken++;
            if (frame_bytes_due.size() == 0) begin
               $error("segment_byte: expected none, actual %02h", rsp_segment_byte);
               failed = 1'b1;
            end else begin
               due = frame_bytes_due.pop_front();
               if (rsp_segment_byte !== due.segment_byte) begin
                  $error("segment_byte: expected %02h, actual %02h",
                         due.segment_byte, rsp_segment_byte);
                  failed = 1'b1;
               end
               if (rsp_last !== due.last) begin
                  $error("last: expected %0b, actual %0b", due.last, rsp_last);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("seven_segment_frame_formatter regression: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned pick;
      logic [2:0]  func;
      logic [31:0] value;

      queue_req(FUNC_STRENGTH, 32'd0);
      queue_req(FUNC_STRENGTH, 32'd9);
      queue_req(FUNC_STRENGTH, 32'd10);
      queue_req(FUNC_STRENGTH, 32'd100);
      queue_req(FUNC_STRENGTH, 32'd101);
      queue_req(FUNC_STRENGTH, 32'hFFFF_FFFF);
      queue_req(FUNC_CUR_TIME, 32'd0);
      queue_req(FUNC_CUR_TIME, 32'd49999);
      queue_req(FUNC_CUR_TIME, 32'd50000);
      queue_req(FUNC_CUR_TIME, 32'd950000);
      queue_req(FUNC_CUR_TIME, 32'd99949999);
      queue_req(FUNC_CUR_TIME, 32'd99950000);
      queue_req(FUNC_CUR_TIME, 32'hFFFF_FFFF);
      queue_req(FUNC_BEST_TIME, 32'd0);
      queue_req(FUNC_BEST_TIME, 32'd99);
      queue_req(FUNC_BEST_TIME, 32'd999);
      queue_req(FUNC_BEST_TIME, 32'd1000);
      queue_req(FUNC_BEST_TIME, 32'd9999);
      queue_req(FUNC_BEST_TIME, 32'd10000);
      queue_req(FUNC_BEST_TIME, 32'hFFFF_FFFF);
      queue_req(FUNC_BLANK_RED, $urandom);
      queue_req(FUNC_BLANK_ALL, $urandom);
      for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++) queue_req(3'(f), $urandom);

      for (int n = 0; n < 145; n++) begin
         pick = $urandom_range(0, 9);
         if (pick <= 2) begin
            func = FUNC_STRENGTH;
            value = $urandom_range(0, 120);
         end else if (pick <= 5) begin
            func = FUNC_CUR_TIME;
            value = $urandom_range(0, 110000000);
         end else if (pick <= 7) begin
            func = FUNC_BEST_TIME;
            value = $urandom_range(0, 12000);
         end else if (pick == 8) begin
            func = $urandom_range(0, 1) ? FUNC_BLANK_RED : FUNC_BLANK_ALL;
            value = $urandom;
         end else begin
            func = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
            value = $urandom;
         end
         if ($urandom_range(0, 7) == 0) value = $urandom;
         queue_req(func, value);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (requests_taken != requests_queued || frame_bytes_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (frame_bytes_due.size() != 0) begin
         $error("segment_byte: %0d expected bytes never arrived", frame_bytes_due.size());
         failed = 1'b1;
      end
      if (!failed) begin
         $display("seven_segment_frame_formatter regression: pass");
      end else begin
         $display("seven_segment_frame_formatter regression: fail");
      end
      $finish;
   end

endmodule
